### rtl/chbd_pkg.sv
// Shared types, constants and helpers of the chunked body decoder.
// Depends on nothing; every other file of the block imports it.
package chbd_pkg;

    localparam int unsigned BodyLimitW = 32;
    localparam int unsigned LineLimitW = 10;
    localparam int unsigned AccumW     = BodyLimitW + 4;

    localparam logic [BodyLimitW-1:0] BODY_LIMIT_RST = 32'd33554432;
    localparam logic [LineLimitW-1:0] LINE_LIMIT_RST = 10'd266;

    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_SEMI = 8'h3B;

    typedef enum logic [1:0] {
        PH_SIZE  = 2'd0,
        PH_DATA  = 2'd1,
        PH_CRLF  = 2'd2,
        PH_TRAIL = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_SIZE_LINE = 3'd1,
        ERR_BAD_HEX   = 3'd2,
        ERR_CHUNK_CAP = 3'd3,
        ERR_NO_DIGITS = 3'd4,
        ERR_BODY_CAP  = 3'd5,
        ERR_NO_CRLF   = 3'd6,
        ERR_TRAIL_LINE = 3'd7
    } err_t;

    typedef enum logic [1:0] {
        FAULT_NONE = 2'd0,
        FAULT_HEX  = 2'd1,
        FAULT_CAP  = 2'd2
    } fault_t;

    typedef enum logic {
        CFG_BODY_LIMIT = 1'b0,
        CFG_LINE_LIMIT = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic       req_type;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic       byte_consumed;
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic       done_res;
        err_t       error_code;
    } result_t;

    // Bit 4 flags a valid hex digit, bits 3:0 hold its value.
    function automatic logic [4:0] hex_decode(input logic [7:0] b);
        logic [4:0] r;
        r = 5'b0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, 4'(b - 8'h30)};
        end else if (b >= 8'h61 && b <= 8'h66) begin
            r = {1'b1, 4'(b - 8'h57)};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            r = {1'b1, 4'(b - 8'h37)};
        end
        return r;
    endfunction

endpackage

### rtl/chbd_in_stage.sv
// Input register of the chunked body decoder: holds one accepted word
// until the decode engine takes it. Depends on chbd_pkg.
module chbd_in_stage (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  chbd_pkg::item_t s_item,
    output logic            item_valid,
    input  logic            item_ready,
    output chbd_pkg::item_t item
);
    import chbd_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  take;
    logic  load;

    assign take    = valid_reg && item_ready;
    assign s_ready = !valid_reg || item_ready;
    assign load    = s_valid && s_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

### rtl/chbd_engine.sv
// Decode engine: framing state, one-word-per-cycle decode while res_ready keeps the
// result register free, and the result register. Depends on chbd_pkg.
module chbd_engine (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [chbd_pkg::BodyLimitW-1:0]     body_limit,
    input  logic [chbd_pkg::LineLimitW-1:0]     line_limit,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  chbd_pkg::item_t                     item,
    output logic                                res_valid,
    input  logic                                res_ready,
    output chbd_pkg::result_t                   res
);
    import chbd_pkg::*;

    phase_t                phase_reg, phase_next;
    logic                  halted_reg, halted_next;
    logic [BodyLimitW-1:0] bytes_owed_reg, bytes_owed_next;
    logic [BodyLimitW-1:0] body_total_reg, body_total_next;
    logic                  crlf_count_reg, crlf_count_next;
    logic [LineLimitW-1:0] line_count_reg, line_count_next;
    logic [AccumW-1:0]     size_accum_reg, size_accum_next;
    logic                  digit_seen_reg, digit_seen_next;
    logic                  scan_stopped_reg, scan_stopped_next;
    fault_t                size_fault_reg, size_fault_next;
    logic                  first_was_cr_reg, first_was_cr_next;
    logic                  res_valid_reg, res_valid_next;
    result_t               res_reg, res_next;

    logic                  advance;
    logic [4:0]            hex;
    logic [BodyLimitW-1:0] owed_dec;
    logic                  go_trail, go_data, go_crlf, go_size;
    err_t                  err;

    assign item_ready = !res_valid_reg || res_ready;
    assign advance    = item_valid && item_ready;
    assign hex        = hex_decode(item.data_byte);
    assign owed_dec   = bytes_owed_reg - BodyLimitW'(bytes_owed_reg != '0);

    // Datapath and result of one word.
    always_comb begin
        bytes_owed_next   = bytes_owed_reg;
        body_total_next   = body_total_reg;
        crlf_count_next   = crlf_count_reg;
        line_count_next   = line_count_reg;
        size_accum_next   = size_accum_reg;
        digit_seen_next   = digit_seen_reg;
        scan_stopped_next = scan_stopped_reg;
        size_fault_next   = size_fault_reg;
        first_was_cr_next = first_was_cr_reg;
        res_next          = '0;
        err               = ERR_NONE;
        go_trail          = 1'b0;
        go_data           = 1'b0;
        go_crlf           = 1'b0;
        go_size           = 1'b0;
        if (item.req_type) begin
            bytes_owed_next   = '0;
            body_total_next   = '0;
            crlf_count_next   = 1'b0;
            line_count_next   = '0;
            size_accum_next   = '0;
            digit_seen_next   = 1'b0;
            scan_stopped_next = 1'b0;
            size_fault_next   = FAULT_NONE;
            first_was_cr_next = 1'b0;
        end else if (!halted_reg) begin
            unique case (phase_reg)
                PH_SIZE: begin
                    if (item.data_byte != CH_LF) begin
                        if (line_count_reg >= line_limit) begin
                            err = ERR_SIZE_LINE;
                        end else begin
                            res_next.byte_consumed = 1'b1;
                            line_count_next = line_count_reg + 1'b1;
                            if (!scan_stopped_reg && size_fault_reg == FAULT_NONE) begin
                                if (item.data_byte == CH_CR || item.data_byte == CH_SEMI) begin
                                    scan_stopped_next = 1'b1;
                                end else if (!hex[4]) begin
                                    size_fault_next = FAULT_HEX;
                                end else begin
                                    // The accumulator never exceeds the cap before the
                                    // shift, so the top nibble drops nothing.
                                    size_accum_next = {size_accum_reg[AccumW-5:0], hex[3:0]};
                                    digit_seen_next = 1'b1;
                                    if (size_accum_next > {4'b0, body_limit}) begin
                                        size_fault_next = FAULT_CAP;
                                    end
                                end
                            end
                        end
                    end else begin
                        res_next.byte_consumed = 1'b1;
                        if (size_fault_reg == FAULT_HEX) begin
                            err = ERR_BAD_HEX;
                        end else if (size_fault_reg == FAULT_CAP) begin
                            err = ERR_CHUNK_CAP;
                        end else if (!digit_seen_reg) begin
                            err = ERR_NO_DIGITS;
                        end else if (size_accum_reg == '0) begin
                            go_trail = 1'b1;
                        end else begin
                            go_data = 1'b1;
                            bytes_owed_next = size_accum_reg[BodyLimitW-1:0];
                        end
                        line_count_next   = '0;
                        size_accum_next   = '0;
                        digit_seen_next   = 1'b0;
                        scan_stopped_next = 1'b0;
                        size_fault_next   = FAULT_NONE;
                        first_was_cr_next = 1'b0;
                    end
                end
                PH_DATA: begin
                    if (body_total_reg >= body_limit) begin
                        err = ERR_BODY_CAP;
                    end else begin
                        res_next.byte_consumed = 1'b1;
                        res_next.payload_valid = 1'b1;
                        res_next.payload_byte  = item.data_byte;
                        body_total_next        = body_total_reg + 1'b1;
                        bytes_owed_next        = owed_dec;
                        if (owed_dec == '0) begin
                            go_crlf         = 1'b1;
                            crlf_count_next = 1'b0;
                        end
                    end
                end
                PH_CRLF: begin
                    res_next.byte_consumed = 1'b1;
                    if (item.data_byte != (crlf_count_reg ? CH_LF : CH_CR)) begin
                        err = ERR_NO_CRLF;
                    end else if (!crlf_count_reg) begin
                        crlf_count_next = 1'b1;
                    end else begin
                        crlf_count_next = 1'b0;
                        go_size         = 1'b1;
                    end
                end
                PH_TRAIL: begin
                    if (item.data_byte != CH_LF) begin
                        if (line_count_reg >= line_limit) begin
                            err = ERR_TRAIL_LINE;
                        end else begin
                            res_next.byte_consumed = 1'b1;
                            if (line_count_reg == '0) begin
                                first_was_cr_next = (item.data_byte == CH_CR);
                            end
                            line_count_next = line_count_reg + 1'b1;
                        end
                    end else begin
                        res_next.byte_consumed = 1'b1;
                        if (line_count_reg == '0 ||
                            (line_count_reg == LineLimitW'(1) && first_was_cr_reg)) begin
                            res_next.done_res = 1'b1;
                        end
                        line_count_next   = '0;
                        first_was_cr_next = 1'b0;
                    end
                end
                default: begin
                    err = ERR_NONE;
                end
            endcase
        end
        res_next.error_code = err;
    end

    // Framing phase and halt flag.
    always_comb begin
        phase_next  = phase_reg;
        halted_next = halted_reg;
        if (item.req_type) begin
            phase_next  = PH_SIZE;
            halted_next = 1'b0;
        end else begin
            priority if (go_trail) begin
                phase_next = PH_TRAIL;
            end else if (go_data) begin
                phase_next = PH_DATA;
            end else if (go_crlf) begin
                phase_next = PH_CRLF;
            end else if (go_size) begin
                phase_next = PH_SIZE;
            end else begin
                phase_next = phase_reg;
            end
            if (err != ERR_NONE || res_next.done_res) begin
                halted_next = 1'b1;
            end
        end
    end

    always_comb begin
        res_valid_next = res_valid_reg;
        if (advance) begin
            res_valid_next = 1'b1;
        end else if (res_ready) begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_SIZE;
            halted_reg       <= 1'b0;
            bytes_owed_reg   <= '0;
            body_total_reg   <= '0;
            crlf_count_reg   <= 1'b0;
            line_count_reg   <= '0;
            size_accum_reg   <= '0;
            digit_seen_reg   <= 1'b0;
            scan_stopped_reg <= 1'b0;
            size_fault_reg   <= FAULT_NONE;
            first_was_cr_reg <= 1'b0;
            res_valid_reg    <= 1'b0;
        end else begin
            res_valid_reg <= res_valid_next;
            if (advance) begin
                phase_reg        <= phase_next;
                halted_reg       <= halted_next;
                bytes_owed_reg   <= bytes_owed_next;
                body_total_reg   <= body_total_next;
                crlf_count_reg   <= crlf_count_next;
                line_count_reg   <= line_count_next;
                size_accum_reg   <= size_accum_next;
                digit_seen_reg   <= digit_seen_next;
                scan_stopped_reg <= scan_stopped_next;
                size_fault_reg   <= size_fault_next;
                first_was_cr_reg <= first_was_cr_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // An error or the end of the trailers stops the decoder.
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && res_next.error_code != ERR_NONE |=> halted_reg)
        else $error("decoder did not halt after an error");

    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && res_next.done_res |=> halted_reg && phase_reg == PH_TRAIL)
        else $error("decoder did not halt after the final blank line");

    // A halted decoder keeps its framing state until a restart.
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && halted_reg && !item.req_type |=> $stable(phase_reg) && halted_reg)
        else $error("halted decoder changed state");

    // A payload chunk always has bytes left while in the payload phase.
    assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_DATA |-> bytes_owed_reg != '0)
        else $error("payload phase with nothing owed");

endmodule

### rtl/http_chunked_body_decoder.sv
// Top level of the HTTP/1.1 chunked body decoder: configuration registers,
// input register and decode engine. Depends on chbd_pkg, chbd_in_stage, chbd_engine.
//
//  Channel | Ports                                   | Moves
//  --------+-----------------------------------------+------------------------------
//  s_      | s_valid/s_ready, s_req_type, s_data_byte | one raw body byte or restart
//  m_      | m_valid/m_ready, m_byte_consumed, ...   | one result word per input word
//  cfg_    | cfg_we, cfg_index, cfg_data             | register write, no handshake
//
// One word is taken per clock while m_ready keeps the result register free. A word is
// decoded straight out of the input register and its result is registered in the result
// register, from which it leaves on the m_ handshake. The single decode stage updates the
// framing state from one word at a time. Reset (aresetn low, synchronous) empties
// both registers, sets the decoder to expect a size line and loads the register
// defaults. A stalled m_ready holds the result and, one word later, s_ready falls.
module http_chunked_body_decoder (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Configuration write port.
    input  logic                            cfg_we,
    input  logic                            cfg_index,
    input  logic [chbd_pkg::BodyLimitW-1:0] cfg_data,
    // Input words.
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_req_type,
    input  logic [7:0]                      s_data_byte,
    // Result words.
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_byte_consumed,
    output logic                            m_payload_valid,
    output logic [7:0]                      m_payload_byte,
    output logic                            m_done_res,
    output logic [2:0]                      m_error_code
);
    import chbd_pkg::*;

    logic [BodyLimitW-1:0] body_limit_reg;
    logic [LineLimitW-1:0] line_limit_reg;

    item_t   s_item;
    item_t   item;
    logic    item_valid;
    logic    item_ready;
    result_t res;

    // The user must write the registers only while the decoder is idle (the block does not
    // enforce it), so a write takes effect on the next word without further care.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            body_limit_reg <= BODY_LIMIT_RST;
            line_limit_reg <= LINE_LIMIT_RST;
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_BODY_LIMIT: body_limit_reg <= cfg_data;
                CFG_LINE_LIMIT: line_limit_reg <= cfg_data[LineLimitW-1:0];
                default:        body_limit_reg <= body_limit_reg;
            endcase
        end
    end

    assign s_item.req_type  = s_req_type;
    assign s_item.data_byte = s_data_byte;

    chbd_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item)
    );

    chbd_engine u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .body_limit (body_limit_reg),
        .line_limit (line_limit_reg),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .res_valid  (m_valid),
        .res_ready  (m_ready),
        .res        (res)
    );

    assign m_byte_consumed = res.byte_consumed;
    assign m_payload_valid = res.payload_valid;
    assign m_payload_byte  = res.payload_byte;
    assign m_done_res      = res.done_res;
    assign m_error_code    = res.error_code;

endmodule
